### hdl/mhpq_pkg.sv
// Shared types and codes for the max-heap priority queue.
`timescale 1ns / 1ps

package mhpq_pkg;

    localparam int DATA_W   = 32;
    localparam int COUNT_W  = 7;
    localparam int STATUS_W = 2;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DELETE = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_UNDERFLOW = 2'd2;

    typedef struct packed {
        logic                     opcode;
        logic signed [DATA_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] top_value;
        logic [COUNT_W-1:0]       entry_count;
        logic [STATUS_W-1:0]      status;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UP_RD,
        ST_UP_CMP,
        ST_DN_LAST,
        ST_DN_LOAD,
        ST_DN_RD,
        ST_DN_CMP,
        ST_PLACE,
        ST_FINISH
    } state_t;

endpackage

### hdl/mhpq_ram.sv
// Heap storage: one write port, two registered read ports.
`timescale 1ns / 1ps

module mhpq_ram #(
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                                clk,
    input  logic                                wr_en,
    input  logic [AW-1:0]                       wr_addr,
    input  logic signed [mhpq_pkg::DATA_W-1:0]  wr_data,
    input  logic [AW-1:0]                       rd_addr_a,
    input  logic [AW-1:0]                       rd_addr_b,
    output logic signed [mhpq_pkg::DATA_W-1:0]  rd_data_a,
    output logic signed [mhpq_pkg::DATA_W-1:0]  rd_data_b
);

    logic signed [mhpq_pkg::DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

### hdl/mhpq_core.sv
// Heap sequencer and datapath: hole-based sift up / sift down over one compare unit.
`timescale 1ns / 1ps

module mhpq_core #(
    parameter int CAPACITY = 64,
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    localparam int CW = $clog2(CAPACITY + 1)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  mhpq_pkg::in_item_t                  in_item,
    output logic                                res_valid,
    input  logic                                res_ready,
    output mhpq_pkg::out_item_t                 res,
    output logic                                wr_en,
    output logic [IW-1:0]                       wr_addr,
    output logic signed [mhpq_pkg::DATA_W-1:0]  wr_data,
    output logic [IW-1:0]                       rd_addr_a,
    output logic [IW-1:0]                       rd_addr_b,
    input  logic signed [mhpq_pkg::DATA_W-1:0]  rd_data_a,
    input  logic signed [mhpq_pkg::DATA_W-1:0]  rd_data_b
);

    localparam int LW = IW + 1;

    mhpq_pkg::state_t state_reg, state_next;

    logic [CW-1:0]                      count_reg;
    logic [IW-1:0]                      hole_reg;
    logic signed [mhpq_pkg::DATA_W-1:0] val_reg;
    logic signed [mhpq_pkg::DATA_W-1:0] top_reg;
    logic [mhpq_pkg::STATUS_W-1:0]      status_reg;

    logic                               full;
    logic                               empty;
    logic                               is_insert;
    logic [IW-1:0]                      parent;
    logic [LW-1:0]                      left;
    logic [LW-1:0]                      right;
    logic [LW-1:0]                      count_ext;
    logic                               left_in;
    logic                               right_in;
    logic                               pick_right;
    logic [IW-1:0]                      child_idx;
    logic signed [mhpq_pkg::DATA_W-1:0] child_val;
    logic signed [mhpq_pkg::DATA_W-1:0] cmp_lhs;
    logic signed [mhpq_pkg::DATA_W-1:0] cmp_rhs;
    logic                               greater;

    assign full      = (count_reg == CW'(CAPACITY));
    assign empty     = (count_reg == '0);
    assign is_insert = (in_item.opcode == mhpq_pkg::OP_INSERT);

    assign parent    = (hole_reg - IW'(1)) >> 1;
    assign left      = {hole_reg, 1'b1};
    assign right     = left + LW'(1);
    assign count_ext = LW'(count_reg);
    assign left_in   = (left < count_ext);
    assign right_in  = (right < count_ext);

    // larger child, left wins on a tie
    assign pick_right = right_in && (rd_data_b > rd_data_a);
    assign child_idx  = pick_right ? right[IW-1:0] : left[IW-1:0];
    assign child_val  = pick_right ? rd_data_b : rd_data_a;

    // the one shared comparator
    always_comb
    begin
        cmp_lhs = child_val;
        cmp_rhs = val_reg;
        if (state_reg == mhpq_pkg::ST_UP_CMP)
        begin
            cmp_lhs = val_reg;
            cmp_rhs = rd_data_a;
        end
    end
    assign greater = (cmp_lhs > cmp_rhs);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mhpq_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (is_insert)
                    begin
                        if (full)
                            state_next = mhpq_pkg::ST_FINISH;
                        else if (empty)
                            state_next = mhpq_pkg::ST_PLACE;
                        else
                            state_next = mhpq_pkg::ST_UP_RD;
                    end
                    else
                    begin
                        state_next = empty ? mhpq_pkg::ST_FINISH : mhpq_pkg::ST_DN_LAST;
                    end
                end
            end
            mhpq_pkg::ST_UP_RD:   state_next = mhpq_pkg::ST_UP_CMP;
            mhpq_pkg::ST_UP_CMP:
            begin
                if (greater && (parent != '0))
                    state_next = mhpq_pkg::ST_UP_RD;
                else
                    state_next = mhpq_pkg::ST_PLACE;
            end
            mhpq_pkg::ST_DN_LAST: state_next = mhpq_pkg::ST_DN_LOAD;
            mhpq_pkg::ST_DN_LOAD: state_next = mhpq_pkg::ST_DN_RD;
            mhpq_pkg::ST_DN_RD:
                state_next = left_in ? mhpq_pkg::ST_DN_CMP : mhpq_pkg::ST_PLACE;
            mhpq_pkg::ST_DN_CMP:
                state_next = greater ? mhpq_pkg::ST_DN_RD : mhpq_pkg::ST_PLACE;
            mhpq_pkg::ST_PLACE:   state_next = mhpq_pkg::ST_FINISH;
            mhpq_pkg::ST_FINISH:
                state_next = res_ready ? mhpq_pkg::ST_IDLE : mhpq_pkg::ST_FINISH;
            default:              state_next = mhpq_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready  = 1'b0;
        res_valid = 1'b0;
        wr_en     = 1'b0;
        wr_addr   = hole_reg;
        wr_data   = val_reg;
        rd_addr_a = '0;
        rd_addr_b = '0;
        case (state_reg)
            mhpq_pkg::ST_IDLE:    in_ready = 1'b1;
            mhpq_pkg::ST_UP_RD:   rd_addr_a = parent;
            mhpq_pkg::ST_UP_CMP:
            begin
                wr_en   = greater;
                wr_data = rd_data_a;
            end
            // count already decremented: it addresses the old last entry
            mhpq_pkg::ST_DN_LAST: rd_addr_a = count_reg[IW-1:0];
            mhpq_pkg::ST_DN_LOAD: ;
            mhpq_pkg::ST_DN_RD:
            begin
                rd_addr_a = left[IW-1:0];
                rd_addr_b = right[IW-1:0];
            end
            mhpq_pkg::ST_DN_CMP:
            begin
                wr_en   = greater;
                wr_data = child_val;
            end
            mhpq_pkg::ST_PLACE:   wr_en = 1'b1;
            mhpq_pkg::ST_FINISH:  res_valid = 1'b1;
            default:              ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mhpq_pkg::ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == mhpq_pkg::ST_IDLE && in_valid)
            begin
                if (is_insert && !full)
                    count_reg <= count_reg + CW'(1);
                else if (!is_insert && !empty)
                    count_reg <= count_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            mhpq_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    val_reg <= in_item.value;
                    if (is_insert)
                    begin
                        hole_reg   <= count_reg[IW-1:0];
                        status_reg <= full ? mhpq_pkg::STATUS_OVERFLOW : mhpq_pkg::STATUS_OK;
                    end
                    else
                    begin
                        hole_reg   <= '0;
                        status_reg <= empty ? mhpq_pkg::STATUS_UNDERFLOW : mhpq_pkg::STATUS_OK;
                    end
                end
            end
            mhpq_pkg::ST_UP_CMP:
            begin
                if (greater)
                    hole_reg <= parent;
            end
            mhpq_pkg::ST_DN_LOAD: val_reg <= rd_data_a;
            mhpq_pkg::ST_DN_CMP:
            begin
                if (greater)
                    hole_reg <= child_idx;
            end
            default: ;
        endcase
        // shadow of the root slot
        if (wr_en && wr_addr == '0)
            top_reg <= wr_data;
    end

    assign res.top_value   = empty ? '0 : top_reg;
    assign res.entry_count = mhpq_pkg::COUNT_W'(count_reg);
    assign res.status      = status_reg;

endmodule

### hdl/max_heap_priority_queue.sv
// Top level of the max-heap priority queue: core, heap storage and result register.
`timescale 1ns / 1ps

// Binary max-heap priority queue of signed 32-bit values.
// Input channel (in_valid/in_ready/in_item): opcode 0 inserts value, opcode 1
// deletes the maximum. Each input beat yields exactly one output beat
// (out_valid/out_ready/out_item) carrying the new maximum (zero when empty),
// the entry count (low 7 bits) and a status: ok, overflow (insert into a full
// heap, value dropped) or underflow (delete from an empty heap, ignored).
// Timing: one item at a time; in_ready is high only while the sequencer idles.
// An insert moves its hole up, reading and comparing one parent per level
// (at most log2(CAPACITY) compares); a delete reads the old last entry, loads
// it, then reads and compares a child pair per level on the way down; overflow
// and underflow go straight to the result. Every level costs a registered read
// of the heap storage and one pass through the shared comparator, and no new
// item is taken until that loop is done.
// Results land in an output register; the next item is accepted while a result
// still waits there, and the sequencer only holds at its final step if the
// register is still occupied when the next result is ready.
// Reset clears the entry count and the control state; the storage needs no
// clearing since values read from slots beyond the entries are never used.
module max_heap_priority_queue #(
    parameter int CAPACITY = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  mhpq_pkg::in_item_t  in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output mhpq_pkg::out_item_t out_item
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic                               res_valid;
    logic                               res_ready;
    mhpq_pkg::out_item_t                res;
    logic                               wr_en;
    logic [IW-1:0]                      wr_addr;
    logic signed [mhpq_pkg::DATA_W-1:0] wr_data;
    logic [IW-1:0]                      rd_addr_a;
    logic [IW-1:0]                      rd_addr_b;
    logic signed [mhpq_pkg::DATA_W-1:0] rd_data_a;
    logic signed [mhpq_pkg::DATA_W-1:0] rd_data_b;

    logic                out_valid_reg;
    mhpq_pkg::out_item_t out_item_reg;

    mhpq_core #(
        .CAPACITY (CAPACITY)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    mhpq_ram #(
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    // result register: free when empty or being drained this cycle
    assign res_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
            out_item_reg <= res;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

`ifndef SYNTHESIS
    // busy after taking a beat
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted twice in a row");

    // overflow only reported when the heap is full
    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.status == mhpq_pkg::STATUS_OVERFLOW)
        |-> (res.entry_count == mhpq_pkg::COUNT_W'(CAPACITY)))
        else $error("overflow with free slots");

    // underflow leaves an empty heap and a zero top
    a_underflow_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.status == mhpq_pkg::STATUS_UNDERFLOW)
        |-> (res.entry_count == '0 && res.top_value == '0))
        else $error("underflow on a non-empty heap");

    // no result beat is produced while the sequencer can take input
    a_result_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !res_valid)
        else $error("result raised while idle");
`endif

endmodule

### sim/testbench.sv
// Self-checking testbench for the max-heap priority queue.
`timescale 1ns / 1ps

module testbench;

    localparam int CAPACITY     = 64;
    localparam int TARGET_ITEMS = 1220;
    localparam int DRAIN_CYCLES = 60;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int MAX_REPORTS  = 10;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    mhpq_pkg::in_item_t  in_item   = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    mhpq_pkg::out_item_t out_item;

    max_heap_priority_queue #(
        .CAPACITY(CAPACITY)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_item  (in_item),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_item (out_item)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Stimulus and scoreboard state
    mhpq_pkg::in_item_t  pending_items[$];
    mhpq_pkg::out_item_t expected_results[$];
    int                  gen_fill;
    int                  total_items;
    int                  accepted_items;
    int                  error_count;
    int                  cycle_count;

    // Mirror of the heap contents
    logic signed [mhpq_pkg::DATA_W-1:0] heap_mirror [0:CAPACITY-1];
    int unsigned                        held_count;

    int n_insert;
    int n_delete;
    int n_overflow;
    int n_underflow;
    int peak_fill;

    function automatic mhpq_pkg::out_item_t predict_heap_op(mhpq_pkg::in_item_t item);
        mhpq_pkg::out_item_t                res;
        int unsigned                        pos;
        int unsigned                        up;
        int unsigned                        lc;
        int unsigned                        rc;
        int unsigned                        best;
        logic signed [mhpq_pkg::DATA_W-1:0] tmp;
        res        = '0;
        res.status = mhpq_pkg::STATUS_OK;
        if (item.opcode == mhpq_pkg::OP_INSERT)
        begin
            n_insert++;
            if (held_count >= CAPACITY)
            begin
                res.status = mhpq_pkg::STATUS_OVERFLOW;
                n_overflow++;
            end
            else
            begin
                heap_mirror[held_count] = item.value;
                held_count++;
                pos = held_count - 1;
                while (pos > 0)
                begin
                    up = (pos - 1) / 2;
                    if (heap_mirror[pos] > heap_mirror[up])
                    begin
                        tmp              = heap_mirror[pos];
                        heap_mirror[pos] = heap_mirror[up];
                        heap_mirror[up]  = tmp;
                        pos              = up;
                    end
                    else
                        break;
                end
            end
        end
        else
        begin
            n_delete++;
            if (held_count == 0)
            begin
                res.status = mhpq_pkg::STATUS_UNDERFLOW;
                n_underflow++;
            end
            else
            begin
                held_count--;
                heap_mirror[0] = heap_mirror[held_count];
                pos = 0;
                while (pos < held_count)
                begin
                    lc   = 2 * pos + 1;
                    rc   = 2 * pos + 2;
                    best = pos;
                    // strict compares: ties keep their place, left child wins
                    if (lc < held_count && heap_mirror[lc] > heap_mirror[best])
                        best = lc;
                    if (rc < held_count && heap_mirror[rc] > heap_mirror[best])
                        best = rc;
                    if (best == pos)
                        break;
                    tmp               = heap_mirror[pos];
                    heap_mirror[pos]  = heap_mirror[best];
                    heap_mirror[best] = tmp;
                    pos               = best;
                end
            end
        end
        if (held_count > peak_fill)
            peak_fill = held_count;
        res.top_value   = (held_count > 0) ? heap_mirror[0] : '0;
        res.entry_count = held_count[mhpq_pkg::COUNT_W-1:0];
        return res;
    endfunction

    // --- stimulus generation ---

    task automatic add_item(input logic op, input logic signed [mhpq_pkg::DATA_W-1:0] val);
        mhpq_pkg::in_item_t item;
        item.opcode = op;
        item.value  = val;
        pending_items = {pending_items, item};
        if (op == mhpq_pkg::OP_INSERT && gen_fill < CAPACITY)
            gen_fill++;
        else if (op == mhpq_pkg::OP_DELETE && gen_fill > 0)
            gen_fill--;
    endtask

    function automatic logic signed [mhpq_pkg::DATA_W-1:0] pick_value();
        logic signed [mhpq_pkg::DATA_W-1:0] v;
        case ($urandom_range(9))
            5, 6:    v = $signed($urandom_range(15)) - 8;    // dense range, many ties
            7:
            begin
                case ($urandom_range(3))
                    0:       v = 32'sh7fff_ffff;
                    1:       v = 32'sh8000_0000;
                    2:       v = '0;
                    default: v = -1;
                endcase
            end
            8:       v = 32'sh7fff_ffff - $urandom_range(3);
            9:       v = 32'sh8000_0000 + $urandom_range(3);
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic build_stimulus();
        int seg;
        int len;
        int ins_pct;
        gen_fill = 0;
        // directed: empty delete, extremes, ties, drain past empty
        add_item(mhpq_pkg::OP_DELETE, 32'sd0);
        add_item(mhpq_pkg::OP_INSERT, 32'sh7fff_ffff);
        add_item(mhpq_pkg::OP_INSERT, 32'sh8000_0000);
        add_item(mhpq_pkg::OP_INSERT, 32'sd0);
        add_item(mhpq_pkg::OP_INSERT, -32'sd1);
        add_item(mhpq_pkg::OP_INSERT, 32'sd1);
        add_item(mhpq_pkg::OP_INSERT, 32'sd5);
        add_item(mhpq_pkg::OP_INSERT, 32'sd5);
        add_item(mhpq_pkg::OP_INSERT, 32'sd5);
        add_item(mhpq_pkg::OP_INSERT, 32'sh8000_0000);
        repeat (10) add_item(mhpq_pkg::OP_DELETE, 32'sh5a5a_a5a5);
        add_item(mhpq_pkg::OP_INSERT, -32'sd7);
        add_item(mhpq_pkg::OP_DELETE, 32'sd0);

        while (pending_items.size() < TARGET_ITEMS)
        begin
            seg = $urandom_range(3);
            case (seg)
                0:
                begin
                    // fill to capacity, then push into the full heap
                    while (gen_fill < CAPACITY)
                        add_item(mhpq_pkg::OP_INSERT, pick_value());
                    repeat ($urandom_range(3, 1)) add_item(mhpq_pkg::OP_INSERT, pick_value());
                end
                1:
                begin
                    while (gen_fill > 0)
                        add_item(mhpq_pkg::OP_DELETE, $urandom);
                    repeat ($urandom_range(2, 1)) add_item(mhpq_pkg::OP_DELETE, $urandom);
                end
                default:
                begin
                    len     = $urandom_range(60, 20);
                    ins_pct = (seg == 2) ? 60 : 35;
                    repeat (len)
                    begin
                        if ($urandom_range(99) < ins_pct)
                            add_item(mhpq_pkg::OP_INSERT, pick_value());
                        else
                            add_item(mhpq_pkg::OP_DELETE, $urandom);
                    end
                end
            endcase
        end
    endtask

    // --- idling profile: three thirds of the run ---

    function automatic int run_phase();
        if (accepted_items < total_items / 3)
            return 0;
        else if (accepted_items < (2 * total_items) / 3)
            return 1;
        return 2;
    endfunction

    function automatic int sender_idle_pct();
        case (run_phase())
            0:       return 11;
            1:       return 73;
            default: return 0;
        endcase
    endfunction

    function automatic int receiver_idle_pct();
        case (run_phase())
            0:       return 73;
            1:       return 11;
            default: return 0;
        endcase
    endfunction

    // --- driver ---

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_item  <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                expected_results = {expected_results, predict_heap_op(in_item)};
                accepted_items++;
            end
            if (!in_valid || in_ready)
            begin
                if (pending_items.size() > 0 && $urandom_range(99) >= sender_idle_pct())
                begin
                    in_valid <= 1'b1;
                    in_item  <= pending_items.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // --- monitor ---

    task automatic check_result(input mhpq_pkg::out_item_t got);
        mhpq_pkg::out_item_t want;
        if (expected_results.size() == 0)
        begin
            error_count++;
            if (error_count <= MAX_REPORTS)
                $display("[%0t] unexpected result beat: top %0d count %0d status %0d",
                         $realtime, got.top_value, got.entry_count, got.status);
            return;
        end
        want = expected_results.pop_front();
        if (got.top_value !== want.top_value || got.entry_count !== want.entry_count
            || got.status !== want.status)
        begin
            error_count++;
            if (error_count <= MAX_REPORTS)
                $display({"[%0t] mismatch: expected top %0d count %0d status %0d, ",
                          "got top %0d count %0d status %0d"},
                         $realtime, want.top_value, want.entry_count, want.status,
                         got.top_value, got.entry_count, got.status);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
                check_result(out_item);
            out_ready <= ($urandom_range(99) >= receiver_idle_pct());
        end
    end

    // --- run control ---

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles", cycle_count);
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        cycle_count    = 0;
        accepted_items = 0;
        error_count    = 0;
        held_count     = 0;
        n_insert       = 0;
        n_delete       = 0;
        n_overflow     = 0;
        n_underflow    = 0;
        peak_fill      = 0;
        build_stimulus();
        total_items = pending_items.size();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        while (accepted_items < total_items || expected_results.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_results.size() > 0)
        begin
            error_count++;
            $display("%0d expected results never arrived", expected_results.size());
        end
        $display("covered %0d inserts (%0d into a full heap) and %0d deletes (%0d on empty)",
                 n_insert, n_overflow, n_delete, n_underflow);
        $display("peak fill %0d of %0d, %0d errors in %0d cycles",
                 peak_fill, CAPACITY, error_count, cycle_count);
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
